>>> rtl/mbeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbeg_pkg
// Shared types, widths, register indexes, reset values and the glyph ramp
// for the escape-time glyph unit.
// ----------------------------------------------------------------------------
package mbeg_pkg;

  // field and datapath widths
  localparam int unsigned COORD_W    = 7;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned C_W        = 32;
  localparam int unsigned ITER_W     = 10;
  localparam int unsigned GLYPH_W    = 7;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned FRAC       = 28;
  localparam int unsigned Z_W        = 33;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RAMP_LAST  = 21;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd5;

  // register reset values
  localparam logic [STEP_W-1:0]        RST_X_STEP   = 31'd9395241;
  localparam logic [STEP_W-1:0]        RST_Y_STEP   = 31'd17895697;
  localparam logic signed [C_W-1:0]    RST_X_OFFSET = 32'sd671088640;
  localparam logic signed [C_W-1:0]    RST_Y_OFFSET = 32'sd268435456;
  localparam logic [STEP_W-1:0]        RST_SCALE    = 31'd268435456;
  localparam logic [ITER_W-1:0]        RST_MAX_ITER = 10'd500;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_column;
    logic [ROW_W-1:0]   pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iteration_count;
    logic               escaped;
    logic [GLYPH_W-1:0] glyph_code;
  } result_t;

  // mapped point c handed from front to back
  typedef struct packed {
    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] cy;
  } point_t;

  // mapping registers as seen by the front
  typedef struct packed {
    logic [STEP_W-1:0]     x_step;
    logic [STEP_W-1:0]     y_step;
    logic signed [C_W-1:0] x_offset;
    logic signed [C_W-1:0] y_offset;
    logic [STEP_W-1:0]     scale;
  } map_cfg_t;

  // min(21, count*42/1000) as a count of passed thresholds
  function automatic logic [IDX_W-1:0] glyph_index(input logic [ITER_W-1:0] count);
    logic [15:0]      weighted;
    logic [IDX_W-1:0] idx;
    weighted = 16'(count) * 16'd42;
    idx = '0;
    for (int k = 1; k <= RAMP_LAST; k++) begin
      if (weighted >= 16'(1000 * k)) idx = IDX_W'(k);
    end
    return idx;
  endfunction

  // brightness ramp " .,~-=+'^"![*oqaOQH@G#"
  function automatic logic [GLYPH_W-1:0] ramp_char(input logic [IDX_W-1:0] idx);
    logic [GLYPH_W-1:0] ch;
    case (idx)
      5'd0:    ch = 7'd32;
      5'd1:    ch = 7'd46;
      5'd2:    ch = 7'd44;
      5'd3:    ch = 7'd126;
      5'd4:    ch = 7'd45;
      5'd5:    ch = 7'd61;
      5'd6:    ch = 7'd43;
      5'd7:    ch = 7'd39;
      5'd8:    ch = 7'd94;
      5'd9:    ch = 7'd34;
      5'd10:   ch = 7'd33;
      5'd11:   ch = 7'd91;
      5'd12:   ch = 7'd42;
      5'd13:   ch = 7'd111;
      5'd14:   ch = 7'd113;
      5'd15:   ch = 7'd97;
      5'd16:   ch = 7'd79;
      5'd17:   ch = 7'd81;
      5'd18:   ch = 7'd72;
      5'd19:   ch = 7'd64;
      5'd20:   ch = 7'd71;
      5'd21:   ch = 7'd35;
      default: ch = 7'd32;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/mbeg_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbeg_map
// Four-stage pipeline mapping one pixel coordinate to a saturated Q4.28
// value: floor((coord*step - offset) * scale / 2^28).
// ----------------------------------------------------------------------------
module mbeg_map (
  input  logic                                clk,
  input  logic [mbeg_pkg::COORD_W-1:0]        coord,
  input  logic [mbeg_pkg::STEP_W-1:0]         step,
  input  logic signed [mbeg_pkg::C_W-1:0]     offset,
  input  logic [mbeg_pkg::STEP_W-1:0]         scale,
  output logic signed [mbeg_pkg::C_W-1:0]     c
);

  localparam int unsigned FRAC   = mbeg_pkg::FRAC;
  localparam int unsigned C_W    = mbeg_pkg::C_W;
  localparam int unsigned STEP_W = mbeg_pkg::STEP_W;
  localparam int unsigned PROD_W = mbeg_pkg::COORD_W + STEP_W;
  localparam int unsigned MAG_W  = PROD_W + 1;
  localparam int unsigned DIFF_W = PROD_W + 2;
  localparam int unsigned HI_W   = MAG_W - FRAC;
  localparam int unsigned HIP_W  = HI_W + STEP_W;
  localparam int unsigned LOP_W  = FRAC + STEP_W;
  localparam int unsigned Q_W    = HIP_W + 1;

  localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(33'h0_8000_0000);

  logic [PROD_W-1:0]        prod;
  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]         mag;
  logic                     neg2;
  logic [HIP_W-1:0]         hi_prod;
  logic [LOP_W-1:0]         lo_prod;
  logic                     neg3;
  logic [Q_W-1:0]           q;
  logic signed [C_W-1:0]    c_next;

  // stage 1: pixel position times pitch
  always_ff @(posedge clk) begin
    prod <= PROD_W'(coord) * PROD_W'(step);
  end

  // stage 2: subtract offset, split sign and magnitude
  assign diff = $signed({2'b00, prod}) - DIFF_W'(offset);

  always_ff @(posedge clk) begin
    neg2 <= diff[DIFF_W-1];
    mag  <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  // stage 3: scale as integer part and fraction part products
  always_ff @(posedge clk) begin
    hi_prod <= HIP_W'(mag[MAG_W-1:FRAC]) * HIP_W'(scale);
    lo_prod <= LOP_W'(mag[FRAC-1:0]) * LOP_W'(scale);
    neg3    <= neg2;
  end

  // stage 4: combine, round toward minus infinity, saturate
  assign q = Q_W'(hi_prod) + Q_W'(lo_prod[LOP_W-1:FRAC])
           + Q_W'(neg3 && (lo_prod[FRAC-1:0] != '0));

  always_comb begin
    if (!neg3) begin
      c_next = (q > POS_LIMIT) ? C_W'(32'h7FFF_FFFF) : $signed(q[C_W-1:0]);
    end else if (q > NEG_LIMIT) begin
      c_next = C_W'(32'h8000_0000);
    end else begin
      c_next = $signed(C_W'(0) - q[C_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    c <= c_next;
  end

endmodule

>>> rtl/mbeg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbeg_front
// Accepts pixels and maps column and row to the point c through two mapping
// pipelines, then pushes c into the point queue.
// ----------------------------------------------------------------------------
module mbeg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mbeg_pkg::pixel_t   pixel,
  output logic               full,
  input  mbeg_pkg::map_cfg_t cfg,
  input  logic               q_full,
  output logic               q_push,
  output mbeg_pkg::point_t   q_data
);

  localparam int unsigned STAGES = 4;

  logic [STAGES-1:0]                  v;
  logic                               accept;
  logic signed [mbeg_pkg::C_W-1:0]    cx;
  logic signed [mbeg_pkg::C_W-1:0]    cy;

  // one pixel in flight; queue room is checked at accept time
  assign full   = (|v) || q_full;
  assign accept = push && !full;
  assign q_push = v[STAGES-1];
  assign q_data = {cx, cy};

  // stage valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[STAGES-2:0], accept};
    end
  end

  // horizontal mapping
  mbeg_map u_map_x (
    .clk    (clk),
    .coord  (pixel.pixel_column),
    .step   (cfg.x_step),
    .offset (cfg.x_offset),
    .scale  (cfg.scale),
    .c      (cx)
  );

  // vertical mapping
  mbeg_map u_map_y (
    .clk    (clk),
    .coord  (mbeg_pkg::COORD_W'(pixel.pixel_row)),
    .step   (cfg.y_step),
    .offset (cfg.y_offset),
    .scale  (cfg.scale),
    .c      (cy)
  );

  // never more than one pixel in the mapping pipeline
  a_single_item: assert property (@(posedge clk) disable iff (rst) $onehot0(v))
    else $error("more than one pixel in the mapping pipeline");

  // the queue slot reserved at accept time is still free at transfer
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    v[STAGES-1] |-> !q_full)
    else $error("mapped point meets a full queue");

endmodule

>>> rtl/mbeg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbeg_queue
// Short first-in first-out queue of mapped points between front and back.
// ----------------------------------------------------------------------------
module mbeg_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mbeg_pkg::point_t push_data,
  output logic             full,
  input  logic             pop,
  output mbeg_pkg::point_t pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  mbeg_pkg::point_t  slot [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/mbeg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbeg_back
// Escape-time iteration, one z = z^2 + c step per cycle, with a result
// register holding count, escape flag and glyph until it is taken.
// ----------------------------------------------------------------------------
module mbeg_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mbeg_pkg::ITER_W-1:0]       max_iterations,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  mbeg_pkg::point_t                  q_data,
  output logic                              empty,
  input  logic                              pop,
  output mbeg_pkg::result_t                 result
);

  localparam int unsigned FRAC  = mbeg_pkg::FRAC;
  localparam int unsigned Z_W   = mbeg_pkg::Z_W;
  localparam int unsigned C_W   = mbeg_pkg::C_W;
  localparam int unsigned P_W   = 2 * Z_W;
  localparam int unsigned SQ_W  = P_W - FRAC;
  localparam int unsigned XY_W  = P_W - FRAC + 1;
  localparam int unsigned SUM_W = SQ_W + 1;
  localparam int unsigned NX_W  = XY_W + 1;
  localparam logic [SUM_W-1:0] FOUR_Q = SUM_W'(64'd4 << FRAC);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                             state;
  logic signed [Z_W-1:0]              zx;
  logic signed [Z_W-1:0]              zy;
  logic signed [C_W-1:0]              cx;
  logic signed [C_W-1:0]              cy;
  logic [mbeg_pkg::ITER_W-1:0]        count;
  logic                               out_valid;

  logic signed [P_W-1:0]              pxx;
  logic signed [P_W-1:0]              pyy;
  logic signed [P_W-1:0]              pxy;
  logic signed [SQ_W-1:0]             sqx;
  logic signed [SQ_W-1:0]             sqy;
  logic signed [XY_W-1:0]             sxy;
  logic [SUM_W-1:0]                   mag_sum;
  logic signed [NX_W-1:0]             nzx;
  logic signed [NX_W-1:0]             nzy;
  logic                               escape;
  logic                               at_limit;
  logic                               finish;
  logic                               room;

  // squares and cross product, floor-truncated by arithmetic shift
  assign pxx = P_W'(zx) * P_W'(zx);
  assign pyy = P_W'(zy) * P_W'(zy);
  assign pxy = P_W'(zx) * P_W'(zy);
  assign sqx = pxx[P_W-1:FRAC];
  assign sqy = pyy[P_W-1:FRAC];
  assign sxy = pxy[P_W-1:FRAC-1];

  // stop tests: magnitude first, then the limit
  assign mag_sum  = SUM_W'(sqx) + SUM_W'(sqy);
  assign escape   = (mag_sum > FOUR_Q);
  assign at_limit = (count >= max_iterations);
  assign finish   = (state == S_RUN) && (escape || at_limit);

  // next z
  assign nzx = NX_W'(sqx) - NX_W'(sqy) + NX_W'(cx);
  assign nzy = NX_W'(sxy) + NX_W'(cy);

  // result slot frees when empty or taken this cycle
  assign room  = !out_valid || pop;
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result takes the slot even when the old one leaves this cycle
      if (finish && room) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) state <= S_RUN;
        end
        S_RUN: begin
          if (finish && room) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // iteration datapath and result register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          cx    <= q_data.cx;
          cy    <= q_data.cy;
          zx    <= '0;
          zy    <= '0;
          count <= '0;
        end
      end
      S_RUN: begin
        if (finish) begin
          if (room) begin
            result.iteration_count <= count;
            result.escaped         <= escape;
            result.glyph_code      <= mbeg_pkg::ramp_char(mbeg_pkg::glyph_index(count));
          end
        end else begin
          zx    <= nzx[Z_W-1:0];
          zy    <= nzy[Z_W-1:0];
          count <= count + 1'b1;
        end
      end
      default: begin
        count <= count;
      end
    endcase
  end

  // a waiting result is neither lost nor changed
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(result)))
    else $error("waiting result lost or changed");

  // every point taken from the queue starts from z = 0 with zero count
  a_fresh_start: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> ((state == S_RUN) && (count == '0) && (zx == '0) && (zy == '0)))
    else $error("iteration did not start clean");

endmodule

>>> rtl/mandelbrot_escape_glyph_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_glyph_unit
// Escape-time evaluator: maps a pixel to c, iterates z = z^2 + c and returns
// the step count, an escape flag and an ASCII brightness glyph.
// ----------------------------------------------------------------------------
// A pixel passes the mapping pipeline into the point queue. The iteration
// unit loads it, runs one z update per cycle through the shared multiply-add
// loop, as many as the reported iteration_count (at most max_iterations),
// and then writes the result. A result still waiting in the output register
// holds the iteration unit until it is taken. The mapper takes a new pixel
// once the previous one is in the point queue and the queue has room, so
// mapping overlaps iteration of the pixel before it; the iteration loop sets
// the sustained rate. The user must see that registers are written only
// while no pixel is pending; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mandelbrot_escape_glyph_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  mbeg_pkg::pixel_t                    pixel,
  output logic                                empty,
  input  logic                                pop,
  output mbeg_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [mbeg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbeg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mbeg_pkg::map_cfg_t                 map_cfg;
  logic [mbeg_pkg::ITER_W-1:0]        max_iterations;
  logic                               q_push;
  logic                               q_pop;
  logic                               q_full;
  logic                               q_empty;
  mbeg_pkg::point_t                   q_in;
  mbeg_pkg::point_t                   q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_cfg.x_step   <= mbeg_pkg::RST_X_STEP;
      map_cfg.y_step   <= mbeg_pkg::RST_Y_STEP;
      map_cfg.x_offset <= mbeg_pkg::RST_X_OFFSET;
      map_cfg.y_offset <= mbeg_pkg::RST_Y_OFFSET;
      map_cfg.scale    <= mbeg_pkg::RST_SCALE;
      max_iterations   <= mbeg_pkg::RST_MAX_ITER;
    end else if (cfg_write) begin
      case (cfg_index)
        mbeg_pkg::REG_X_STEP:   map_cfg.x_step   <= cfg_data[mbeg_pkg::STEP_W-1:0];
        mbeg_pkg::REG_Y_STEP:   map_cfg.y_step   <= cfg_data[mbeg_pkg::STEP_W-1:0];
        mbeg_pkg::REG_X_OFFSET: map_cfg.x_offset <= $signed(cfg_data);
        mbeg_pkg::REG_Y_OFFSET: map_cfg.y_offset <= $signed(cfg_data);
        mbeg_pkg::REG_SCALE:    map_cfg.scale    <= cfg_data[mbeg_pkg::STEP_W-1:0];
        mbeg_pkg::REG_MAX_ITER: max_iterations   <= cfg_data[mbeg_pkg::ITER_W-1:0];
        default:                max_iterations   <= max_iterations;
      endcase
    end
  end

  // coordinate mapping
  mbeg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pixel  (pixel),
    .full   (full),
    .cfg    (map_cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // point queue
  mbeg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // iteration and result
  mbeg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_data         (q_out),
    .empty          (empty),
    .pop            (pop),
    .result         (result)
  );

endmodule

>>> tb/mandelbrot_escape_glyph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_glyph_checker
// Watches the pixel, result and register channels of the escape-time glyph
// unit, predicts each pixel's count, escape flag and glyph from its own copy
// of the registers, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module mandelbrot_escape_glyph_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  mbeg_pkg::pixel_t                    pixel,
  input  logic                                empty,
  input  logic                                pop,
  input  mbeg_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [mbeg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbeg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  mismatches,
  output int                                  pixels_in_flight
);

  // wide enough for exact mapping products and z squares
  localparam int WIDE = 80;
  localparam logic signed [WIDE-1:0] RADIUS_SQ = 80'sd4 <<< mbeg_pkg::FRAC;

  // local copy of the register file
  logic [mbeg_pkg::STEP_W-1:0]     x_pitch;
  logic [mbeg_pkg::STEP_W-1:0]     y_pitch;
  logic signed [mbeg_pkg::C_W-1:0] x_pan;
  logic signed [mbeg_pkg::C_W-1:0] y_pan;
  logic [mbeg_pkg::STEP_W-1:0]     zoom;
  logic [mbeg_pkg::ITER_W-1:0]     iter_limit;

  string             glyph_ramp = " .,~-=+'^\"![*oqaOQH@G#";
  mbeg_pkg::result_t predicted_pixels[$];
  mbeg_pkg::result_t oldest;

  // floor((pos*pitch - pan) * zoom / 2^28), clamped to 32 bits signed
  function automatic logic signed [mbeg_pkg::C_W-1:0] map_axis(
      input logic [11:0] pos,
      input logic [mbeg_pkg::STEP_W-1:0] pitch,
      input logic signed [mbeg_pkg::C_W-1:0] pan,
      input logic [mbeg_pkg::STEP_W-1:0] factor);
    logic signed [WIDE-1:0] p;
    logic signed [WIDE-1:0] s;
    logic signed [WIDE-1:0] o;
    logic signed [WIDE-1:0] f;
    logic signed [WIDE-1:0] q;
    p = WIDE'(pos);
    s = WIDE'(pitch);
    o = WIDE'(pan);
    f = WIDE'(factor);
    q = ((p * s - o) * f) >>> mbeg_pkg::FRAC;
    if (q > 80'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -80'sd2147483648) return 32'h8000_0000;
    return q[mbeg_pkg::C_W-1:0];
  endfunction

  // escape-time iteration and glyph lookup for one pixel
  function automatic mbeg_pkg::result_t escape_result(input mbeg_pkg::pixel_t px);
    logic signed [WIDE-1:0] cx;
    logic signed [WIDE-1:0] cy;
    logic signed [WIDE-1:0] zx;
    logic signed [WIDE-1:0] zy;
    logic signed [WIDE-1:0] sqx;
    logic signed [WIDE-1:0] sqy;
    logic signed [WIDE-1:0] next_x;
    int                     steps;
    int                     level;
    bit                     done;
    mbeg_pkg::result_t      r;
    cx = WIDE'(map_axis(12'(px.pixel_column), x_pitch, x_pan, zoom));
    cy = WIDE'(map_axis(12'(px.pixel_row), y_pitch, y_pan, zoom));
    zx = '0;
    zy = '0;
    steps = 0;
    done = 1'b0;
    r = '0;
    // magnitude test ahead of the limit test
    while (!done) begin
      sqx = (zx * zx) >>> mbeg_pkg::FRAC;
      sqy = (zy * zy) >>> mbeg_pkg::FRAC;
      if (sqx + sqy > RADIUS_SQ) begin
        r.escaped = 1'b1;
        done = 1'b1;
      end else if (steps >= int'(iter_limit)) begin
        done = 1'b1;
      end else begin
        next_x = sqx - sqy + cx;
        zy = ((zx * zy) >>> (mbeg_pkg::FRAC - 1)) + cy;
        zx = next_x;
        steps++;
      end
    end
    level = steps * 42 / 1000;
    if (level > int'(mbeg_pkg::RAMP_LAST)) level = int'(mbeg_pkg::RAMP_LAST);
    r.iteration_count = mbeg_pkg::ITER_W'(steps);
    r.glyph_code = mbeg_pkg::GLYPH_W'(glyph_ramp[level]);
    return r;
  endfunction

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      x_pitch    = mbeg_pkg::RST_X_STEP;
      y_pitch    = mbeg_pkg::RST_Y_STEP;
      x_pan      = mbeg_pkg::RST_X_OFFSET;
      y_pan      = mbeg_pkg::RST_Y_OFFSET;
      zoom       = mbeg_pkg::RST_SCALE;
      iter_limit = mbeg_pkg::RST_MAX_ITER;
      mismatches = 0;
      predicted_pixels.delete();
    end else begin
      // pixel transfer: predict with the registers in force now
      if (push && !full) predicted_pixels.push_back(escape_result(pixel));

      // result transfer: compare with the oldest prediction
      if (pop && !empty) begin
        if (predicted_pixels.size() == 0) begin
          mismatches++;
          $error("result transfer with no pixel outstanding: count %0d escaped %0d glyph %0d",
                 result.iteration_count, result.escaped, result.glyph_code);
        end else begin
          oldest = predicted_pixels.pop_front();
          if (result.iteration_count !== oldest.iteration_count) begin
            mismatches++;
            $error("iteration_count: expected %0d, got %0d",
                   oldest.iteration_count, result.iteration_count);
          end
          if (result.escaped !== oldest.escaped) begin
            mismatches++;
            $error("escaped: expected %0d, got %0d", oldest.escaped, result.escaped);
          end
          if (result.glyph_code !== oldest.glyph_code) begin
            mismatches++;
            $error("glyph_code: expected %0d, got %0d", oldest.glyph_code, result.glyph_code);
          end
        end
      end

      // register writes, unmapped indexes fall through
      if (cfg_write) begin
        case (cfg_index)
          mbeg_pkg::REG_X_STEP:   x_pitch    = cfg_data[mbeg_pkg::STEP_W-1:0];
          mbeg_pkg::REG_Y_STEP:   y_pitch    = cfg_data[mbeg_pkg::STEP_W-1:0];
          mbeg_pkg::REG_X_OFFSET: x_pan      = cfg_data[mbeg_pkg::C_W-1:0];
          mbeg_pkg::REG_Y_OFFSET: y_pan      = cfg_data[mbeg_pkg::C_W-1:0];
          mbeg_pkg::REG_SCALE:    zoom       = cfg_data[mbeg_pkg::STEP_W-1:0];
          mbeg_pkg::REG_MAX_ITER: iter_limit = cfg_data[mbeg_pkg::ITER_W-1:0];
          default: ;
        endcase
      end
    end
    pixels_in_flight = predicted_pixels.size();
  end

endmodule

>>> tb/mandelbrot_escape_glyph_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_glyph_unit_test
// Drives pixels and register settings into the escape-time glyph unit with
// random gaps and result back-pressure: a directed set of views and edge
// pixels first, then random views; the checker beside the block does the
// comparing and this top gives the verdict.
// ----------------------------------------------------------------------------
module mandelbrot_escape_glyph_unit_test;

  localparam int RANDOM_PIXELS  = 1190;
  localparam int IDLE_PERCENT   = 31;
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int TAIL_CYCLES    = 1030;
  localparam int SQUEEZE_AFTER  = 300;
  localparam int SQUEEZE_CYCLES = 2000;
  localparam int STEADY_PHASE   = 3;

  // indexes with no register behind them
  localparam logic [mbeg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [mbeg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                            clk;
  logic                            rst;
  logic                            push;
  logic                            full;
  mbeg_pkg::pixel_t                pixel;
  logic                            empty;
  logic                            pop;
  mbeg_pkg::result_t               result;
  logic                            cfg_write;
  logic [mbeg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mbeg_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pixels_in_flight;
  int accepted_pixels;
  int cycle_count;
  bit steady;

  mandelbrot_escape_glyph_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mandelbrot_escape_glyph_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .pixel            (pixel),
    .empty            (empty),
    .pop              (pop),
    .result           (result),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pixels_in_flight (pixels_in_flight)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off after SQUEEZE_AFTER pixels
  initial begin : result_sink
    int hold;
    bit squeezed;
    pop = 1'b0;
    hold = 0;
    squeezed = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!squeezed && accepted_pixels >= SQUEEZE_AFTER) begin
        squeezed = 1;
        hold = SQUEEZE_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // one pixel transfer, with random gaps ahead of it
  task automatic send_pixel(input logic [mbeg_pkg::COORD_W-1:0] col,
                            input logic [mbeg_pkg::ROW_W-1:0] row);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push  <= 1'b1;
    pixel <= {col, row};
    @(posedge clk);
    while (full) @(posedge clk);
    accepted_pixels++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_until_idle;
    @(negedge clk);
    push <= 1'b0;
    while (pixels_in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mbeg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mbeg_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // full register set, optionally with writes to the unmapped indexes
  task automatic load_view(input logic [31:0] xs, input logic [31:0] ys,
                           input logic [31:0] xo, input logic [31:0] yo,
                           input logic [31:0] sc, input logic [31:0] lim,
                           input bit spare);
    write_reg(mbeg_pkg::REG_X_STEP, xs);
    write_reg(mbeg_pkg::REG_Y_STEP, ys);
    write_reg(mbeg_pkg::REG_X_OFFSET, xo);
    write_reg(mbeg_pkg::REG_Y_OFFSET, yo);
    if (spare) begin
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SPARE_HI, $urandom);
    end
    write_reg(mbeg_pkg::REG_SCALE, sc);
    write_reg(mbeg_pkg::REG_MAX_ITER, lim);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int          phase;
    int          random_sent;
    int          batch;
    logic [31:0] xs, ys, xo, yo, sc, lim;
    push = 1'b0;
    pixel = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 0;
    accepted_pixels = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset view: frame corners, points inside the set and near its edge
    send_pixel(7'd0, 5'd0);
    send_pixel(7'd127, 5'd31);
    send_pixel(7'd127, 5'd0);
    send_pixel(7'd0, 5'd31);
    send_pixel(7'd71, 5'd15);
    send_pixel(7'd57, 5'd15);
    send_pixel(7'd71, 5'd31);
    send_pixel(7'd40, 5'd10);

    // zero iteration limit
    wait_until_idle;
    load_view(32'(mbeg_pkg::RST_X_STEP), 32'(mbeg_pkg::RST_Y_STEP),
              mbeg_pkg::RST_X_OFFSET, mbeg_pkg::RST_Y_OFFSET,
              32'(mbeg_pkg::RST_SCALE), 32'd0, 0);
    send_pixel(7'd0, 5'd0);
    send_pixel(7'd71, 5'd15);
    send_pixel(7'd127, 5'd31);

    // saturated c in both directions, limit of one: escape and limit coincide
    wait_until_idle;
    load_view(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FC01, 1);
    send_pixel(7'd0, 5'd0);
    send_pixel(7'd127, 5'd31);
    send_pixel(7'd0, 5'd31);
    send_pixel(7'd127, 5'd0);

    // c at the origin with the largest limit
    wait_until_idle;
    load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1023, 0);
    send_pixel(7'd0, 5'd0);
    send_pixel(7'd127, 5'd31);

    // tiny negative and positive c: floor rounding of the mapping
    wait_until_idle;
    load_view(32'd1, 32'd3, 32'd7, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'd40, 0);
    send_pixel(7'd0, 5'd0);
    send_pixel(7'd6, 5'd2);
    send_pixel(7'd7, 5'd1);
    send_pixel(7'd127, 5'd31);

    // random views, mostly framed around the set, some with raw register values
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      wait_until_idle;
      phase++;
      steady = (phase == STEADY_PHASE);
      if ($urandom_range(0, 4) == 0) begin
        xs = $urandom;
        ys = $urandom;
        xo = $urandom;
        yo = $urandom;
        sc = $urandom;
      end else begin
        xs = $urandom_range(0, 32'h0200_0000) | ($urandom & 32'h8000_0000);
        ys = $urandom_range(0, 32'h0400_0000) | ($urandom & 32'h8000_0000);
        xo = $urandom_range(0, 32'h6000_0000) - 32'h2000_0000;
        yo = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        sc = $urandom_range(32'h0400_0000, 32'h2000_0000) | ($urandom & 32'h8000_0000);
      end
      if ($urandom_range(0, 9) == 0) begin
        lim = 32'd1023;
        batch = 8;
      end else begin
        lim = $urandom_range(0, 100);
        batch = $urandom_range(40, 120);
      end
      lim = lim | ($urandom & 32'hFFFF_FC00);
      if (batch > RANDOM_PIXELS - random_sent) batch = RANDOM_PIXELS - random_sent;
      load_view(xs, ys, xo, yo, sc, lim, $urandom_range(0, 3) == 0);
      repeat (batch) send_pixel(mbeg_pkg::COORD_W'($urandom_range(0, 127)),
                                mbeg_pkg::ROW_W'($urandom_range(0, 31)));
      random_sent += batch;
    end

    wait_until_idle;
    steady = 0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pixels_in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
